>>> sv/packed_simd_integer_alu_top_defines.svh
// Assertion macros for the packed SIMD integer ALU checker.
// Depends on nothing; the including module must provide clk and rst.
`ifndef PACKED_SIMD_INTEGER_ALU_TOP_DEFINES_SVH
`define PACKED_SIMD_INTEGER_ALU_TOP_DEFINES_SVH

// Implication checked at every rising edge outside reset.
`define PSALU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition that holds at every rising edge outside reset.
`define PSALU_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

`endif

>>> sv/psalu_pkg.sv
// Package for the packed SIMD integer ALU: operation codes and lane functions.
// Used by the top level and its checker; depends on nothing.
package psalu_pkg;

  localparam logic [5:0] OP_PACKSSWB  = 6'd0;
  localparam logic [5:0] OP_PACKSSDW  = 6'd1;
  localparam logic [5:0] OP_PACKUSWB  = 6'd2;
  localparam logic [5:0] OP_PADDB     = 6'd3;
  localparam logic [5:0] OP_PADDW     = 6'd4;
  localparam logic [5:0] OP_PADDD     = 6'd5;
  localparam logic [5:0] OP_PADDSB    = 6'd6;
  localparam logic [5:0] OP_PADDSW    = 6'd7;
  localparam logic [5:0] OP_PADDUSB   = 6'd8;
  localparam logic [5:0] OP_PADDUSW   = 6'd9;
  localparam logic [5:0] OP_PMADDWD   = 6'd10;
  localparam logic [5:0] OP_PMULHW    = 6'd11;
  localparam logic [5:0] OP_PMULHUW   = 6'd12;
  localparam logic [5:0] OP_PMULLW    = 6'd13;
  localparam logic [5:0] OP_PSLLB     = 6'd14;
  localparam logic [5:0] OP_PSLLW     = 6'd15;
  localparam logic [5:0] OP_PSLLD     = 6'd16;
  localparam logic [5:0] OP_PSLLQ     = 6'd17;
  localparam logic [5:0] OP_PSRLB     = 6'd18;
  localparam logic [5:0] OP_PSRLW     = 6'd19;
  localparam logic [5:0] OP_PSRLD     = 6'd20;
  localparam logic [5:0] OP_PSRLQ     = 6'd21;
  localparam logic [5:0] OP_PSRAW     = 6'd22;
  localparam logic [5:0] OP_PSRAD     = 6'd23;
  localparam logic [5:0] OP_PSUBB     = 6'd24;
  localparam logic [5:0] OP_PSUBW     = 6'd25;
  localparam logic [5:0] OP_PSUBD     = 6'd26;
  localparam logic [5:0] OP_PSUBSB    = 6'd27;
  localparam logic [5:0] OP_PSUBSW    = 6'd28;
  localparam logic [5:0] OP_PSUBUSB   = 6'd29;
  localparam logic [5:0] OP_PSUBUSW   = 6'd30;
  localparam logic [5:0] OP_PUNPCKHBW = 6'd31;
  localparam logic [5:0] OP_PUNPCKHWD = 6'd32;
  localparam logic [5:0] OP_PUNPCKHDQ = 6'd33;
  localparam logic [5:0] OP_PUNPCKLBW = 6'd34;
  localparam logic [5:0] OP_PUNPCKLWD = 6'd35;
  localparam logic [5:0] OP_PUNPCKLDQ = 6'd36;

  localparam logic [1:0] SAT_NONE     = 2'd0;
  localparam logic [1:0] SAT_SIGNED   = 2'd1;
  localparam logic [1:0] SAT_UNSIGNED = 2'd2;

  function automatic logic [7:0] sat_s16_s8(logic [15:0] x);
    return (x[15:7] == 9'h000 || x[15:7] == 9'h1FF) ? x[7:0] : (x[15] ? 8'h80 : 8'h7F);
  endfunction

  function automatic logic [7:0] sat_s16_u8(logic [15:0] x);
    return x[15] ? 8'h00 : ((x[15:8] != 8'h00) ? 8'hFF : x[7:0]);
  endfunction

  function automatic logic [15:0] sat_s32_s16(logic [31:0] x);
    return (x[31:15] == 17'h00000 || x[31:15] == 17'h1FFFF) ? x[15:0]
         : (x[31] ? 16'h8000 : 16'h7FFF);
  endfunction

  function automatic logic [63:0] pack_wb(logic [63:0] d, logic [63:0] s, logic uns);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      r[8*i +: 8]      = uns ? sat_s16_u8(d[16*i +: 16]) : sat_s16_s8(d[16*i +: 16]);
      r[32 + 8*i +: 8] = uns ? sat_s16_u8(s[16*i +: 16]) : sat_s16_s8(s[16*i +: 16]);
    end
    return r;
  endfunction

  function automatic logic [63:0] pack_dw(logic [63:0] d, logic [63:0] s);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < 2; i++) begin
      r[16*i +: 16]      = sat_s32_s16(d[32*i +: 32]);
      r[32 + 16*i +: 16] = sat_s32_s16(s[32*i +: 32]);
    end
    return r;
  endfunction

  function automatic logic [63:0] addsub_b(logic [63:0] d, logic [63:0] s, logic sub,
                                           logic [1:0] mode);
    logic [8:0] sx;
    logic [8:0] ux;
    logic [7:0] x;
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      sx = sub ? ({d[8*i+7], d[8*i +: 8]} - {s[8*i+7], s[8*i +: 8]})
               : ({d[8*i+7], d[8*i +: 8]} + {s[8*i+7], s[8*i +: 8]});
      ux = sub ? ({1'b0, d[8*i +: 8]} - {1'b0, s[8*i +: 8]})
               : ({1'b0, d[8*i +: 8]} + {1'b0, s[8*i +: 8]});
      case (mode)
        SAT_SIGNED:   x = (sx[8] != sx[7]) ? (sx[8] ? 8'h80 : 8'h7F) : sx[7:0];
        SAT_UNSIGNED: x = ux[8] ? (sub ? 8'h00 : 8'hFF) : ux[7:0];
        default:      x = ux[7:0];
      endcase
      r[8*i +: 8] = x;
    end
    return r;
  endfunction

  function automatic logic [63:0] addsub_w(logic [63:0] d, logic [63:0] s, logic sub,
                                           logic [1:0] mode);
    logic [16:0] sx;
    logic [16:0] ux;
    logic [15:0] x;
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      sx = sub ? ({d[16*i+15], d[16*i +: 16]} - {s[16*i+15], s[16*i +: 16]})
               : ({d[16*i+15], d[16*i +: 16]} + {s[16*i+15], s[16*i +: 16]});
      ux = sub ? ({1'b0, d[16*i +: 16]} - {1'b0, s[16*i +: 16]})
               : ({1'b0, d[16*i +: 16]} + {1'b0, s[16*i +: 16]});
      case (mode)
        SAT_SIGNED:   x = (sx[16] != sx[15]) ? (sx[16] ? 16'h8000 : 16'h7FFF) : sx[15:0];
        SAT_UNSIGNED: x = ux[16] ? (sub ? 16'h0000 : 16'hFFFF) : ux[15:0];
        default:      x = ux[15:0];
      endcase
      r[16*i +: 16] = x;
    end
    return r;
  endfunction

  function automatic logic [63:0] addsub_d(logic [63:0] d, logic [63:0] s, logic sub);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < 2; i++) begin
      r[32*i +: 32] = sub ? (d[32*i +: 32] - s[32*i +: 32]) : (d[32*i +: 32] + s[32*i +: 32]);
    end
    return r;
  endfunction

  // Four 17x17 signed multipliers; the extra bit is the sign or zero.
  function automatic logic [127:0] mul_lanes(logic [63:0] d, logic [63:0] s, logic sgn);
    logic signed [16:0] a;
    logic signed [16:0] b;
    logic signed [33:0] p;
    logic [127:0] r;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      a = $signed({sgn & d[16*i+15], d[16*i +: 16]});
      b = $signed({sgn & s[16*i+15], s[16*i +: 16]});
      p = a * b;
      r[32*i +: 32] = p[31:0];
    end
    return r;
  endfunction

  function automatic logic [63:0] shift_b(logic [63:0] v, logic [7:0] cnt, logic left);
    logic [63:0] r;
    r = '0;
    if (cnt <= 8'd7) begin
      for (int i = 0; i < 8; i++) begin
        r[8*i +: 8] = left ? (v[8*i +: 8] << cnt[2:0]) : (v[8*i +: 8] >> cnt[2:0]);
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] shift_w(logic [63:0] v, logic [7:0] cnt, logic left);
    logic [63:0] r;
    r = '0;
    if (cnt <= 8'd15) begin
      for (int i = 0; i < 4; i++) begin
        r[16*i +: 16] = left ? (v[16*i +: 16] << cnt[3:0]) : (v[16*i +: 16] >> cnt[3:0]);
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] shift_d(logic [63:0] v, logic [7:0] cnt, logic left);
    logic [63:0] r;
    r = '0;
    if (cnt <= 8'd31) begin
      for (int i = 0; i < 2; i++) begin
        r[32*i +: 32] = left ? (v[32*i +: 32] << cnt[4:0]) : (v[32*i +: 32] >> cnt[4:0]);
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] shift_q(logic [63:0] v, logic [7:0] cnt, logic left);
    logic [63:0] r;
    r = '0;
    if (cnt <= 8'd63) begin
      r = left ? (v << cnt[5:0]) : (v >> cnt[5:0]);
    end
    return r;
  endfunction

  function automatic logic [63:0] sra_w(logic [63:0] v, logic [7:0] cnt);
    logic [3:0] c;
    logic [63:0] r;
    c = (cnt > 8'd15) ? 4'd15 : cnt[3:0];
    r = '0;
    for (int i = 0; i < 4; i++) begin
      r[16*i +: 16] = $signed(v[16*i +: 16]) >>> c;
    end
    return r;
  endfunction

  function automatic logic [63:0] sra_d(logic [63:0] v, logic [7:0] cnt);
    logic [4:0] c;
    logic [63:0] r;
    c = (cnt > 8'd31) ? 5'd31 : cnt[4:0];
    r = '0;
    for (int i = 0; i < 2; i++) begin
      r[32*i +: 32] = $signed(v[32*i +: 32]) >>> c;
    end
    return r;
  endfunction

  function automatic logic [63:0] unpack_b(logic [63:0] d, logic [63:0] s, logic high);
    logic [31:0] dh;
    logic [31:0] sh;
    logic [63:0] r;
    dh = high ? d[63:32] : d[31:0];
    sh = high ? s[63:32] : s[31:0];
    r = '0;
    for (int i = 0; i < 4; i++) begin
      r[16*i +: 8]     = dh[8*i +: 8];
      r[16*i + 8 +: 8] = sh[8*i +: 8];
    end
    return r;
  endfunction

  function automatic logic [63:0] unpack_w(logic [63:0] d, logic [63:0] s, logic high);
    logic [31:0] dh;
    logic [31:0] sh;
    dh = high ? d[63:32] : d[31:0];
    sh = high ? s[63:32] : s[31:0];
    return {sh[31:16], dh[31:16], sh[15:0], dh[15:0]};
  endfunction

  function automatic logic [63:0] unpack_d(logic [63:0] d, logic [63:0] s, logic high);
    return high ? {s[63:32], d[63:32]} : {s[31:0], d[31:0]};
  endfunction

endpackage

>>> sv/packed_simd_integer_alu_top.sv
// Packed SIMD integer ALU: input register, one pass of lane logic, result register.
// Depends on psalu_pkg for operation codes and lane functions.
// An accepted beat passes the input register and then the result register, with done.
// Throughput: one beat per cycle; busy stays low, since the datapath is a two-stage pipe.
// The cycle is set by the four 17x17 lane multipliers followed by the multiply-add adder.
// Reset clears the two valid flags only; no result appears until a beat is accepted.
module packed_simd_integer_alu_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [5:0]  op,
  input  logic [63:0] dest_operand,
  input  logic [63:0] src_operand,
  input  logic [7:0]  shift_count,
  output logic        done,
  output logic [63:0] result
);

  logic        in_valid;
  logic [5:0]  op_q;
  logic [63:0] dest_q;
  logic [63:0] src_q;
  logic [7:0]  cnt_q;
  logic [127:0] prod;
  logic [63:0] result_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      in_valid <= start && !busy;
      done     <= in_valid;
    end
    if (start && !busy) begin
      op_q   <= op;
      dest_q <= dest_operand;
      src_q  <= src_operand;
      cnt_q  <= shift_count;
    end
    if (in_valid) begin
      result <= result_next;
    end
  end

  always_comb begin
    prod = psalu_pkg::mul_lanes(dest_q, src_q, op_q != psalu_pkg::OP_PMULHUW);
    unique case (op_q)
      psalu_pkg::OP_PACKSSWB:  result_next = psalu_pkg::pack_wb(dest_q, src_q, 1'b0);
      psalu_pkg::OP_PACKSSDW:  result_next = psalu_pkg::pack_dw(dest_q, src_q);
      psalu_pkg::OP_PACKUSWB:  result_next = psalu_pkg::pack_wb(dest_q, src_q, 1'b1);
      psalu_pkg::OP_PADDB:
        result_next = psalu_pkg::addsub_b(dest_q, src_q, 1'b0, psalu_pkg::SAT_NONE);
      psalu_pkg::OP_PADDW:
        result_next = psalu_pkg::addsub_w(dest_q, src_q, 1'b0, psalu_pkg::SAT_NONE);
      psalu_pkg::OP_PADDD:     result_next = psalu_pkg::addsub_d(dest_q, src_q, 1'b0);
      psalu_pkg::OP_PADDSB:
        result_next = psalu_pkg::addsub_b(dest_q, src_q, 1'b0, psalu_pkg::SAT_SIGNED);
      psalu_pkg::OP_PADDSW:
        result_next = psalu_pkg::addsub_w(dest_q, src_q, 1'b0, psalu_pkg::SAT_SIGNED);
      psalu_pkg::OP_PADDUSB:
        result_next = psalu_pkg::addsub_b(dest_q, src_q, 1'b0, psalu_pkg::SAT_UNSIGNED);
      psalu_pkg::OP_PADDUSW:
        result_next = psalu_pkg::addsub_w(dest_q, src_q, 1'b0, psalu_pkg::SAT_UNSIGNED);
      psalu_pkg::OP_PMADDWD:
        result_next = {prod[127:96] + prod[95:64], prod[63:32] + prod[31:0]};
      psalu_pkg::OP_PMULHW, psalu_pkg::OP_PMULHUW:
        result_next = {prod[127:112], prod[95:80], prod[63:48], prod[31:16]};
      psalu_pkg::OP_PMULLW:
        result_next = {prod[111:96], prod[79:64], prod[47:32], prod[15:0]};
      psalu_pkg::OP_PSLLB:     result_next = psalu_pkg::shift_b(dest_q, cnt_q, 1'b1);
      psalu_pkg::OP_PSLLW:     result_next = psalu_pkg::shift_w(dest_q, cnt_q, 1'b1);
      psalu_pkg::OP_PSLLD:     result_next = psalu_pkg::shift_d(dest_q, cnt_q, 1'b1);
      psalu_pkg::OP_PSLLQ:     result_next = psalu_pkg::shift_q(dest_q, cnt_q, 1'b1);
      psalu_pkg::OP_PSRLB:     result_next = psalu_pkg::shift_b(dest_q, cnt_q, 1'b0);
      psalu_pkg::OP_PSRLW:     result_next = psalu_pkg::shift_w(dest_q, cnt_q, 1'b0);
      psalu_pkg::OP_PSRLD:     result_next = psalu_pkg::shift_d(dest_q, cnt_q, 1'b0);
      psalu_pkg::OP_PSRLQ:     result_next = psalu_pkg::shift_q(dest_q, cnt_q, 1'b0);
      psalu_pkg::OP_PSRAW:     result_next = psalu_pkg::sra_w(dest_q, cnt_q);
      psalu_pkg::OP_PSRAD:     result_next = psalu_pkg::sra_d(dest_q, cnt_q);
      psalu_pkg::OP_PSUBB:
        result_next = psalu_pkg::addsub_b(dest_q, src_q, 1'b1, psalu_pkg::SAT_NONE);
      psalu_pkg::OP_PSUBW:
        result_next = psalu_pkg::addsub_w(dest_q, src_q, 1'b1, psalu_pkg::SAT_NONE);
      psalu_pkg::OP_PSUBD:     result_next = psalu_pkg::addsub_d(dest_q, src_q, 1'b1);
      psalu_pkg::OP_PSUBSB:
        result_next = psalu_pkg::addsub_b(dest_q, src_q, 1'b1, psalu_pkg::SAT_SIGNED);
      psalu_pkg::OP_PSUBSW:
        result_next = psalu_pkg::addsub_w(dest_q, src_q, 1'b1, psalu_pkg::SAT_SIGNED);
      psalu_pkg::OP_PSUBUSB:
        result_next = psalu_pkg::addsub_b(dest_q, src_q, 1'b1, psalu_pkg::SAT_UNSIGNED);
      psalu_pkg::OP_PSUBUSW:
        result_next = psalu_pkg::addsub_w(dest_q, src_q, 1'b1, psalu_pkg::SAT_UNSIGNED);
      psalu_pkg::OP_PUNPCKHBW: result_next = psalu_pkg::unpack_b(dest_q, src_q, 1'b1);
      psalu_pkg::OP_PUNPCKHWD: result_next = psalu_pkg::unpack_w(dest_q, src_q, 1'b1);
      psalu_pkg::OP_PUNPCKHDQ: result_next = psalu_pkg::unpack_d(dest_q, src_q, 1'b1);
      psalu_pkg::OP_PUNPCKLBW: result_next = psalu_pkg::unpack_b(dest_q, src_q, 1'b0);
      psalu_pkg::OP_PUNPCKLWD: result_next = psalu_pkg::unpack_w(dest_q, src_q, 1'b0);
      psalu_pkg::OP_PUNPCKLDQ: result_next = psalu_pkg::unpack_d(dest_q, src_q, 1'b0);
      default:                 result_next = dest_q;
    endcase
  end

endmodule

>>> sv/psalu_checker.sv
// Port-level checker for the packed SIMD integer ALU, bound to the top level.
// Depends on psalu_pkg and packed_simd_integer_alu_top_defines.svh.
`include "packed_simd_integer_alu_top_defines.svh"

module psalu_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [5:0]  op,
  input logic [63:0] dest_operand,
  input logic [7:0]  shift_count,
  input logic        done,
  input logic [63:0] result
);

  `PSALU_ASSERT_ALWAYS(a_never_busy, !busy, "busy rose although the pipe never stalls")
  `PSALU_ASSERT_IMP(a_beat_delivered, (start && !busy) ##1 !rst ##1 1'b1, done,
                    "accepted beat produced no result")
  `PSALU_ASSERT_IMP(a_no_phantom, done, $past(start && !busy, 2),
                    "result without an accepted beat")
  `PSALU_ASSERT_IMP(a_unused_op, done && ($past(op, 2) > psalu_pkg::OP_PUNPCKLDQ),
                    result == $past(dest_operand, 2), "unused opcode changed the destination")
  `PSALU_ASSERT_IMP(a_big_shift,
                    done && ($past(op, 2) >= psalu_pkg::OP_PSLLB)
                    && ($past(op, 2) <= psalu_pkg::OP_PSRLQ) && ($past(shift_count, 2) >= 8'd64),
                    result == 64'd0, "logical shift past lane width left bits set")

endmodule

bind packed_simd_integer_alu_top psalu_checker u_psalu_checker (.*);

>>> tb/packed_alu_checker.sv
// Checker for the packed SIMD integer ALU: watches beats and results, predicts each
// result lane by lane and compares it with what the block returns, in order.
// Depends on psalu_pkg for the operation and saturation codes.
module packed_alu_checker
  import psalu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [5:0]  op,
  input  logic [63:0] dest_operand,
  input  logic [63:0] src_operand,
  input  logic [7:0]  shift_count,
  input  logic        done,
  input  logic [63:0] result,
  output int          mismatch_count,
  output int          pending_count
);

  localparam int MUL_HIGH_SIGNED   = 0;
  localparam int MUL_HIGH_UNSIGNED = 1;
  localparam int MUL_LOW           = 2;
  localparam int REPORT_LIMIT      = 10;

  typedef struct {
    logic [5:0]  opc;
    logic [63:0] dest;
    logic [63:0] src;
    logic [7:0]  count;
    logic [63:0] packed_result;
  } alu_expectation_t;

  alu_expectation_t expected_results[$];

  function automatic logic [63:0] lane_mask(int w);
    return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
  endfunction

  function automatic logic [63:0] lane_of(logic [63:0] v, int i, int w);
    return (v >> (i * w)) & lane_mask(w);
  endfunction

  function automatic longint lane_signed(logic [63:0] v, int w);
    longint t;
    t = v << (64 - w);
    return t >>> (64 - w);
  endfunction

  function automatic longint limit_range(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [63:0] lanes_add_sub(logic [63:0] d, logic [63:0] s, int w,
                                                bit subtract, logic [1:0] sat);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] m;
    logic [63:0] x;
    logic [63:0] r;
    longint sa;
    longint sb;
    longint lim;
    m = lane_mask(w);
    lim = longint'(1) << (w - 1);
    r = '0;
    for (int i = 0; i < 64 / w; i++) begin
      a = lane_of(d, i, w);
      b = lane_of(s, i, w);
      case (sat)
        SAT_SIGNED: begin
          sa = lane_signed(a, w);
          sb = lane_signed(b, w);
          x = limit_range(subtract ? sa - sb : sa + sb, -lim, lim - 1);
        end
        SAT_UNSIGNED: begin
          sa = longint'(a);
          sb = longint'(b);
          x = limit_range(subtract ? sa - sb : sa + sb, 0, longint'(m));
        end
        default: x = subtract ? a - b : a + b;
      endcase
      r |= (x & m) << (i * w);
    end
    return r;
  endfunction

  function automatic logic [63:0] saturating_pack(logic [63:0] d, logic [63:0] s, int sw,
                                                  longint lo, longint hi);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] r;
    int dw;
    int n;
    dw = sw / 2;
    n = 64 / sw;
    r = '0;
    for (int i = 0; i < n; i++) begin
      x = limit_range(lane_signed(lane_of(d, i, sw), sw), lo, hi);
      y = limit_range(lane_signed(lane_of(s, i, sw), sw), lo, hi);
      r |= (x & lane_mask(dw)) << (i * dw);
      r |= (y & lane_mask(dw)) << ((i + n) * dw);
    end
    return r;
  endfunction

  function automatic logic [63:0] logical_shift(logic [63:0] v, int w, int cnt, bit left);
    logic [63:0] a;
    logic [63:0] r;
    r = '0;
    if (cnt > w - 1) return r;
    for (int i = 0; i < 64 / w; i++) begin
      a = lane_of(v, i, w);
      r |= ((left ? (a << cnt) : (a >> cnt)) & lane_mask(w)) << (i * w);
    end
    return r;
  endfunction

  function automatic logic [63:0] arithmetic_shift(logic [63:0] v, int w, int cnt);
    logic [63:0] x;
    logic [63:0] r;
    int c;
    c = (cnt > w - 1) ? w - 1 : cnt;
    r = '0;
    for (int i = 0; i < 64 / w; i++) begin
      x = lane_signed(lane_of(v, i, w), w) >>> c;
      r |= (x & lane_mask(w)) << (i * w);
    end
    return r;
  endfunction

  function automatic logic [63:0] interleave(logic [63:0] d, logic [63:0] s, int w, bit high);
    logic [63:0] r;
    int half;
    int base;
    half = 32 / w;
    base = high ? half : 0;
    r = '0;
    for (int i = 0; i < half; i++) begin
      r |= lane_of(d, base + i, w) << (2 * i * w);
      r |= lane_of(s, base + i, w) << ((2 * i + 1) * w);
    end
    return r;
  endfunction

  function automatic logic [63:0] word_multiply(logic [63:0] d, logic [63:0] s, int kind);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] x;
    logic [63:0] r;
    longint p;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      a = lane_of(d, i, 16);
      b = lane_of(s, i, 16);
      case (kind)
        MUL_HIGH_SIGNED: begin
          p = lane_signed(a, 16) * lane_signed(b, 16);
          x = p >>> 16;
        end
        MUL_HIGH_UNSIGNED: begin
          p = longint'(a) * longint'(b);
          x = p >> 16;
        end
        default: begin
          p = longint'(a) * longint'(b);
          x = p;
        end
      endcase
      r |= (x & lane_mask(16)) << (16 * i);
    end
    return r;
  endfunction

  function automatic logic [63:0] multiply_accumulate(logic [63:0] d, logic [63:0] s);
    logic [63:0] x;
    logic [63:0] r;
    longint sum;
    r = '0;
    for (int j = 0; j < 2; j++) begin
      sum = lane_signed(lane_of(d, 2 * j, 16), 16) * lane_signed(lane_of(s, 2 * j, 16), 16)
          + lane_signed(lane_of(d, 2 * j + 1, 16), 16)
          * lane_signed(lane_of(s, 2 * j + 1, 16), 16);
      x = sum;
      r |= (x & lane_mask(32)) << (32 * j);
    end
    return r;
  endfunction

  function automatic logic [63:0] predict_packed_result(logic [5:0] opc, logic [63:0] d,
                                                        logic [63:0] s, logic [7:0] count);
    int c;
    c = int'(count);
    case (opc)
      OP_PACKSSWB:  return saturating_pack(d, s, 16, -128, 127);
      OP_PACKSSDW:  return saturating_pack(d, s, 32, -32768, 32767);
      OP_PACKUSWB:  return saturating_pack(d, s, 16, 0, 255);
      OP_PADDB:     return lanes_add_sub(d, s, 8, 1'b0, SAT_NONE);
      OP_PADDW:     return lanes_add_sub(d, s, 16, 1'b0, SAT_NONE);
      OP_PADDD:     return lanes_add_sub(d, s, 32, 1'b0, SAT_NONE);
      OP_PADDSB:    return lanes_add_sub(d, s, 8, 1'b0, SAT_SIGNED);
      OP_PADDSW:    return lanes_add_sub(d, s, 16, 1'b0, SAT_SIGNED);
      OP_PADDUSB:   return lanes_add_sub(d, s, 8, 1'b0, SAT_UNSIGNED);
      OP_PADDUSW:   return lanes_add_sub(d, s, 16, 1'b0, SAT_UNSIGNED);
      OP_PMADDWD:   return multiply_accumulate(d, s);
      OP_PMULHW:    return word_multiply(d, s, MUL_HIGH_SIGNED);
      OP_PMULHUW:   return word_multiply(d, s, MUL_HIGH_UNSIGNED);
      OP_PMULLW:    return word_multiply(d, s, MUL_LOW);
      OP_PSLLB:     return logical_shift(d, 8, c, 1'b1);
      OP_PSLLW:     return logical_shift(d, 16, c, 1'b1);
      OP_PSLLD:     return logical_shift(d, 32, c, 1'b1);
      OP_PSLLQ:     return logical_shift(d, 64, c, 1'b1);
      OP_PSRLB:     return logical_shift(d, 8, c, 1'b0);
      OP_PSRLW:     return logical_shift(d, 16, c, 1'b0);
      OP_PSRLD:     return logical_shift(d, 32, c, 1'b0);
      OP_PSRLQ:     return logical_shift(d, 64, c, 1'b0);
      OP_PSRAW:     return arithmetic_shift(d, 16, c);
      OP_PSRAD:     return arithmetic_shift(d, 32, c);
      OP_PSUBB:     return lanes_add_sub(d, s, 8, 1'b1, SAT_NONE);
      OP_PSUBW:     return lanes_add_sub(d, s, 16, 1'b1, SAT_NONE);
      OP_PSUBD:     return lanes_add_sub(d, s, 32, 1'b1, SAT_NONE);
      OP_PSUBSB:    return lanes_add_sub(d, s, 8, 1'b1, SAT_SIGNED);
      OP_PSUBSW:    return lanes_add_sub(d, s, 16, 1'b1, SAT_SIGNED);
      OP_PSUBUSB:   return lanes_add_sub(d, s, 8, 1'b1, SAT_UNSIGNED);
      OP_PSUBUSW:   return lanes_add_sub(d, s, 16, 1'b1, SAT_UNSIGNED);
      OP_PUNPCKHBW: return interleave(d, s, 8, 1'b1);
      OP_PUNPCKHWD: return interleave(d, s, 16, 1'b1);
      OP_PUNPCKHDQ: return interleave(d, s, 32, 1'b1);
      OP_PUNPCKLBW: return interleave(d, s, 8, 1'b0);
      OP_PUNPCKLWD: return interleave(d, s, 16, 1'b0);
      OP_PUNPCKLDQ: return interleave(d, s, 32, 1'b0);
      default:      return d;
    endcase
  endfunction

  always @(posedge clk) begin
    alu_expectation_t exp_beat;
    if (rst) begin
      expected_results.delete();
      mismatch_count = 0;
    end else begin
      if (start && !busy) begin
        exp_beat.opc = op;
        exp_beat.dest = dest_operand;
        exp_beat.src = src_operand;
        exp_beat.count = shift_count;
        exp_beat.packed_result = predict_packed_result(op, dest_operand, src_operand,
                                                       shift_count);
        expected_results.push_back(exp_beat);
      end
      if (done) begin
        if (expected_results.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT)
            $display("ERROR: result %h arrived with no beat outstanding", result);
          mismatch_count++;
        end else begin
          exp_beat = expected_results.pop_front();
          if (result !== exp_beat.packed_result) begin
            if (mismatch_count < REPORT_LIMIT)
              $display("ERROR: op %0d dest %h src %h count %0d: expected %h, got %h",
                       exp_beat.opc, exp_beat.dest, exp_beat.src, exp_beat.count,
                       exp_beat.packed_result, result);
            mismatch_count++;
          end
        end
      end
    end
    pending_count = expected_results.size();
  end

endmodule

>>> tb/testbench.sv
// Top of the packed SIMD integer ALU testbench: clock, reset, directed and random beats
// under three sender pacing phases, a stall watchdog and the verdict.
// Depends on psalu_pkg, packed_simd_integer_alu_top and packed_alu_checker.
module testbench;
  import psalu_pkg::*;

  localparam logic [5:0] OP_FIRST_UNUSED = 6'd37;
  localparam logic [5:0] OP_LAST_CODE    = 6'd63;
  localparam int         STALL_LIMIT     = 4000;
  localparam int         DRAIN_CYCLES    = 8;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [5:0]  op;
  logic [63:0] dest_operand;
  logic [63:0] src_operand;
  logic [7:0]  shift_count;
  logic        done;
  logic [63:0] result;
  int          mismatch_count;
  int          pending_count;
  int          sender_idle_pct;
  int          beats_sent;
  int          results_seen;
  int          quiet_cycles;

  packed_simd_integer_alu_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .dest_operand(dest_operand), .src_operand(src_operand), .shift_count(shift_count),
    .done(done), .result(result)
  );

  packed_alu_checker alu_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .dest_operand(dest_operand), .src_operand(src_operand), .shift_count(shift_count),
    .done(done), .result(result), .mismatch_count(mismatch_count),
    .pending_count(pending_count)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
      results_seen <= 0;
    end else begin
      if (done) results_seen <= results_seen + 1;
      if ((start && !busy) || done) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no beat or result for %0d cycles", STALL_LIMIT);
        $display("testbench failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_beat(input logic [5:0] o, input logic [63:0] d, input logic [63:0] s,
                           input logic [7:0] c);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    op <= o;
    dest_operand <= d;
    src_operand <= s;
    shift_count <= c;
    do @(posedge clk); while (busy);
    beats_sent++;
  endtask

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    int kind;
    kind = $urandom_range(3);
    v = {$urandom, $urandom};
    if (kind == 2) begin
      for (int i = 0; i < 8; i++) begin
        case ($urandom_range(5))
          0: v[8*i +: 8] = 8'h00;
          1: v[8*i +: 8] = 8'h7F;
          2: v[8*i +: 8] = 8'h80;
          3: v[8*i +: 8] = 8'hFF;
          4: v[8*i +: 8] = 8'h01;
          default: ;
        endcase
      end
    end else if (kind == 3) begin
      for (int i = 0; i < 4; i++) begin
        case ($urandom_range(5))
          0: v[16*i +: 16] = 16'h0000;
          1: v[16*i +: 16] = 16'h7FFF;
          2: v[16*i +: 16] = 16'h8000;
          3: v[16*i +: 16] = 16'hFFFF;
          4: v[16*i +: 16] = 16'h0001;
          default: ;
        endcase
      end
    end
    return v;
  endfunction

  task automatic run_random(input int count);
    logic [5:0] o;
    logic [7:0] c;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(19) == 0) o = 6'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE));
      else o = 6'($urandom_range(OP_PACKSSWB, OP_PUNPCKLDQ));
      if ($urandom_range(3) == 0) c = 8'($urandom_range(255));
      else c = 8'($urandom_range(66));
      send_beat(o, rand_operand(), rand_operand(), c);
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    op = OP_PACKSSWB;
    dest_operand = '0;
    src_operand = '0;
    shift_count = '0;
    beats_sent = 0;
    sender_idle_pct = 37;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Saturation extremes, multiply-add wrap, oversized shift counts, unused codes.
    send_beat(OP_PACKSSWB, 64'h8000_7FFF_FF80_007F, 64'h0080_FF7F_0000_FFFF, 8'd0);
    send_beat(OP_PACKSSDW, 64'h8000_0000_7FFF_FFFF, 64'hFFFF_8000_0000_7FFF, 8'd0);
    send_beat(OP_PACKUSWB, 64'h8000_7FFF_00FF_0100, 64'hFFFF_0000_0080_00FF, 8'd0);
    send_beat(OP_PADDSB, 64'h7F80_7F80_0102_FF00, 64'h0180_7F80_FEFE_0101, 8'd0);
    send_beat(OP_PADDUSW, 64'hFFFF_8000_0001_0000, 64'h0001_8000_FFFF_0000, 8'd0);
    send_beat(OP_PSUBSW, 64'h8000_7FFF_0000_FFFF, 64'h0001_FFFF_8000_7FFF, 8'd0);
    send_beat(OP_PSUBUSB, 64'h0001_FF00_8080_0000, 64'h0100_00FF_7F81_0001, 8'd0);
    send_beat(OP_PADDD, '1, 64'h0000_0001_0000_0001, 8'd255);
    send_beat(OP_PSUBB, '0, '1, 8'd255);
    send_beat(OP_PMADDWD, 64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000, 8'd0);
    send_beat(OP_PMULHW, 64'h8000_7FFF_FFFF_8000, 64'h8000_7FFF_0001_7FFF, 8'd0);
    send_beat(OP_PMULHUW, 64'hFFFF_8000_FFFF_0001, 64'hFFFF_8000_0002_FFFF, 8'd0);
    send_beat(OP_PMULLW, '1, '1, 8'd0);
    send_beat(OP_PSLLB, '1, '0, 8'd7);
    send_beat(OP_PSLLB, '1, '0, 8'd8);
    send_beat(OP_PSRLW, '1, '0, 8'd15);
    send_beat(OP_PSRLW, '1, '0, 8'd16);
    send_beat(OP_PSLLD, '1, '0, 8'd32);
    send_beat(OP_PSRLQ, '1, '0, 8'd63);
    send_beat(OP_PSLLQ, '1, '0, 8'd64);
    send_beat(OP_PSRAW, 64'h8000_7FFF_FFFF_0001, '0, 8'd255);
    send_beat(OP_PSRAD, 64'h8000_0000_7FFF_FFFF, '0, 8'd32);
    send_beat(OP_PUNPCKHBW, 64'h0011_2233_4455_6677, 64'h8899_AABB_CCDD_EEFF, 8'd0);
    send_beat(OP_PUNPCKLDQ, 64'h0011_2233_4455_6677, 64'h8899_AABB_CCDD_EEFF, 8'd0);
    send_beat(OP_FIRST_UNUSED, 64'h0123_4567_89AB_CDEF, '1, 8'd0);
    send_beat(OP_LAST_CODE, 64'hFEDC_BA98_7654_3210, '0, 8'd255);

    run_random(370);
    sender_idle_pct = 83;
    run_random(370);
    sender_idle_pct = 0;
    run_random(360);

    @(negedge clk);
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Run covered %0d beats and %0d results: saturation and shift corners,",
             beats_sent, results_seen);
    $display("every opcode plus unused codes, with sender idling at 37%%, 83%% and none.");
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/psalu_pkg.sv
sv/packed_simd_integer_alu_top.sv
sv/psalu_checker.sv
tb/packed_alu_checker.sv
tb/testbench.sv
